// ----- hw/rtl/oaht_pkg.sv -----
// Shared types and constants of the open-addressing hash table.
// Used by the controller, the datapath, the top level and the checker.
// Depends on nothing.
package oaht_pkg;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_LOOKUP = 1'b1;

   // The home slot is found by reciprocal multiplication: a quotient step, then a remainder step.
   localparam int          MOD_STEPS  = 2;
   localparam int          MOD_CNT_W  = 1;
   localparam logic [0:0]  MOD_LAST   = 1'(MOD_STEPS - 1);

   typedef enum logic [2:0] {
      ST_INSERTED  = 3'd0,
      ST_FULL      = 3'd1,
      ST_NO_PATH   = 3'd2,
      ST_FOUND     = 3'd3,
      ST_NOT_FOUND = 3'd4
   } status_type;

   typedef struct packed {
      logic        func;
      logic [31:0] key;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [2:0]  slot;
      logic [3:0]  probes;
   } rsp_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_MOD,
      S_START,
      S_READ,
      S_CHECK,
      S_DONE
   } state_type;

   typedef struct packed {
      logic       clear;
      logic       load;
      logic       mod_step;
      logic       path_init;
      logic       advance;
      logic       write;
      logic       set_status;
      status_type status;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic mod_done;
      logic table_full;
      logic is_lookup;
      logic slot_free;
      logic key_match;
      logic last_probe;
      logic out_free;
   } sts_type;

endpackage

// ----- hw/rtl/oaht_ctrl.sv -----
// Controller state machine of the open-addressing hash table.
// Sequences clearing, home-slot reduction, probing and result hand-off.
// Depends on oaht_pkg.
module oaht_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  oaht_pkg::sts_type sts,
   output oaht_pkg::cmd_type cmd
);

   oaht_pkg::state_type state_ff;
   oaht_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= oaht_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.status = oaht_pkg::ST_INSERTED;
      req_ready  = 1'b0;
      unique case (state_ff)
         oaht_pkg::S_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_done) begin
               state_in = oaht_pkg::S_IDLE;
            end
         end
         oaht_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = oaht_pkg::S_MOD;
            end
         end
         oaht_pkg::S_MOD: begin
            cmd.mod_step = 1'b1;
            if (sts.mod_done) begin
               state_in = oaht_pkg::S_START;
            end
         end
         oaht_pkg::S_START: begin
            if (!sts.is_lookup && sts.table_full) begin
               cmd.set_status = 1'b1;
               cmd.status     = oaht_pkg::ST_FULL;
               state_in       = oaht_pkg::S_DONE;
            end else begin
               cmd.path_init = 1'b1;
               state_in      = oaht_pkg::S_READ;
            end
         end
         oaht_pkg::S_READ: begin
            state_in = oaht_pkg::S_CHECK;
         end
         oaht_pkg::S_CHECK: begin
            if (!sts.is_lookup && sts.slot_free) begin
               cmd.write      = 1'b1;
               cmd.set_status = 1'b1;
               cmd.status     = oaht_pkg::ST_INSERTED;
               state_in       = oaht_pkg::S_DONE;
            end else if (sts.is_lookup && sts.key_match) begin
               cmd.set_status = 1'b1;
               cmd.status     = oaht_pkg::ST_FOUND;
               state_in       = oaht_pkg::S_DONE;
            end else if (sts.last_probe) begin
               cmd.set_status = 1'b1;
               cmd.status     = sts.is_lookup ? oaht_pkg::ST_NOT_FOUND
                                              : oaht_pkg::ST_NO_PATH;
               state_in       = oaht_pkg::S_DONE;
            end else begin
               cmd.advance = 1'b1;
               state_in    = oaht_pkg::S_READ;
            end
         end
         oaht_pkg::S_DONE: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = oaht_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = oaht_pkg::S_CLEAR;
         end
      endcase
   end

endmodule

// ----- hw/rtl/oaht_dpath.sv -----
// Datapath of the open-addressing hash table: slot memory, home-slot
// reduction, probe address generation, fill count and result register.
// Depends on oaht_pkg.
module oaht_dpath #(
   parameter int TABLE_SIZE = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data,
   input  oaht_pkg::req_type req_data,
   input  oaht_pkg::cmd_type cmd,
   output oaht_pkg::sts_type sts,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output oaht_pkg::rsp_type rsp_data
);

   localparam int AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
   localparam int CW = $clog2(2 * TABLE_SIZE);
   localparam int FW = $clog2(TABLE_SIZE + 1);

   localparam logic [32:0] RECIP = 33'(((65'd1 << (32 + AW)) / 65'(TABLE_SIZE)) + 65'd1);
   localparam logic [AW-1:0] SIZE_LO = AW'(TABLE_SIZE);
   localparam logic [AW:0]   SIZE_A  = (AW + 1)'(TABLE_SIZE);
   localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_SIZE - 1);
   localparam logic [CW-1:0] LAST_LIN  = CW'(TABLE_SIZE - 1);
   localparam logic [CW-1:0] LAST_QUAD = CW'(2 * TABLE_SIZE - 2);
   localparam logic [FW-1:0] FILL_MAX  = FW'(TABLE_SIZE);

   logic [32:0] mem [TABLE_SIZE];
   logic [32:0] rd_ff;

   logic        mode_ff;
   logic        func_ff;
   logic [31:0] key_ff;
   logic [AW-1:0] q_lo_ff;
   logic [AW-1:0] r_ff;
   logic [AW-1:0] r_in;
   logic [oaht_pkg::MOD_CNT_W-1:0] dig_ff;
   logic [AW-1:0] p_ff;
   logic [CW-1:0] n_ff;
   logic [CW-1:0] n_in;
   logic [AW-1:0] off_ff;
   logic [AW-1:0] t_ff;
   logic [FW-1:0] fill_ff;
   logic [AW-1:0] clr_ff;
   oaht_pkg::status_type status_ff;
   logic              rsp_valid_ff;
   oaht_pkg::rsp_type rsp_data_ff;
   oaht_pkg::rsp_type rsp_data_in;

   logic [64:0]   prod;
   logic [AW-1:0] qs_lo;
   logic [AW-1:0] lin_next;
   logic [AW:0]   sum_ot;
   logic [AW-1:0] off_new;
   logic [AW:0]   sum_t;
   logic [AW-1:0] t_new;
   logic [AW:0]   sum_plus;
   logic [AW-1:0] p_plus;
   logic [AW:0]   sum_minus;
   logic [AW-1:0] p_minus;
   logic          hit;

   // The home slot is the key less the quotient times the size; only the low
   // bits of the quotient are needed since the remainder is below the size.
   always_comb begin
      prod  = {33'd0, key_ff} * {32'd0, RECIP};
      qs_lo = q_lo_ff * SIZE_LO;
      r_in  = key_ff[AW-1:0] - qs_lo;
   end

   // The squared offset is kept modulo the size and grows by the next odd number.
   always_comb begin
      n_in     = n_ff + CW'(1);
      lin_next = (p_ff == LAST_SLOT) ? '0 : p_ff + AW'(1);
      sum_ot   = {1'b0, off_ff} + {1'b0, t_ff};
      off_new  = (sum_ot >= SIZE_A) ? AW'(sum_ot - SIZE_A) : sum_ot[AW-1:0];
      sum_t    = {1'b0, t_ff} + (AW + 1)'(2);
      t_new    = (sum_t >= SIZE_A) ? AW'(sum_t - SIZE_A) : sum_t[AW-1:0];
      sum_plus = {1'b0, r_ff} + {1'b0, off_new};
      p_plus   = (sum_plus >= SIZE_A) ? AW'(sum_plus - SIZE_A) : sum_plus[AW-1:0];
      sum_minus = ({1'b0, r_ff} + SIZE_A) - {1'b0, off_ff};
      p_minus  = (sum_minus >= SIZE_A) ? AW'(sum_minus - SIZE_A) : sum_minus[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         mem[clr_ff] <= '0;
      end else if (cmd.write) begin
         mem[p_ff] <= {1'b1, key_ff};
      end
      rd_ff <= mem[p_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         fill_ff      <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
         if (cmd.write) begin
            fill_ff <= fill_ff + FW'(1);
         end
         if (cmd.clear) begin
            clr_ff <= clr_ff + AW'(1);
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff   <= req_data.func;
         key_ff    <= req_data.key;
         dig_ff    <= '0;
      end else if (cmd.mod_step) begin
         q_lo_ff   <= prod[32 + AW +: AW];
         r_ff      <= r_in;
         dig_ff    <= dig_ff + oaht_pkg::MOD_CNT_W'(1);
      end
      if (cmd.path_init) begin
         p_ff   <= r_ff;
         n_ff   <= '0;
         off_ff <= '0;
         t_ff   <= AW'(1);
      end else if (cmd.advance) begin
         n_ff <= n_in;
         if (!mode_ff) begin
            p_ff <= lin_next;
         end else if (n_in[0]) begin
            off_ff <= off_new;
            t_ff   <= t_new;
            p_ff   <= p_plus;
         end else begin
            p_ff <= p_minus;
         end
      end
      if (cmd.set_status) begin
         status_ff <= cmd.status;
      end
      if (cmd.out_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_comb begin
      hit = (status_ff == oaht_pkg::ST_INSERTED) || (status_ff == oaht_pkg::ST_FOUND);
      rsp_data_in.status = status_ff;
      rsp_data_in.slot   = hit ? 3'(p_ff) : 3'd0;
      rsp_data_in.probes = (status_ff == oaht_pkg::ST_FULL) ? 4'd0 : 4'(n_in);
   end

   always_comb begin
      sts.clear_done = (clr_ff == LAST_SLOT);
      sts.mod_done   = (dig_ff == oaht_pkg::MOD_LAST);
      sts.table_full = (fill_ff == FILL_MAX);
      sts.is_lookup  = (func_ff == oaht_pkg::FUNC_LOOKUP);
      sts.slot_free  = !rd_ff[32];
      sts.key_match  = rd_ff[32] && (rd_ff[31:0] == key_ff);
      sts.last_probe = (n_ff == (mode_ff ? LAST_QUAD : LAST_LIN));
      sts.out_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- hw/rtl/open_addressing_hash_table.sv -----
// Top level of the open-addressing hash table with linear or quadratic probing.
// Joins oaht_ctrl and oaht_dpath; types come from oaht_pkg.
//
//   Channel   Ports                           Carries
//   request   req_valid/req_ready/req_data    func and key of one item
//   response  rsp_valid/rsp_ready/rsp_data    status, slot and probes of one item
//   config    csr_wr_en/csr_wr_data           probe_mode, written with no wait
//
// Each slot probed for an item takes one memory read and one compare; the home slot
// is found first by reciprocal multiplication, and an insert into a full table is
// answered without probing. After reset a clearing pass empties every slot before
// the first item is accepted. A result waits in an output register, so the next item
// is taken in while the previous result is still unread.
module open_addressing_hash_table #(
   parameter int TABLE_SIZE = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data,
   input  logic              req_valid,
   output logic              req_ready,
   input  oaht_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output oaht_pkg::rsp_type rsp_data
);

   oaht_pkg::cmd_type cmd;
   oaht_pkg::sts_type sts;

   oaht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   oaht_dpath #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_data    (req_data),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

endmodule

// ----- hw/rtl/oaht_checker.sv -----
// Port-level checker of the open-addressing hash table and its bind statement.
// Depends on oaht_pkg and on the open_addressing_hash_table ports.
module oaht_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input oaht_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("A stalled response item changed or was dropped.");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= oaht_pkg::ST_NOT_FOUND)
      else $error("A response item carries an unknown status.");

   a_full_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == oaht_pkg::ST_FULL
         |-> rsp_data.slot == 3'd0 && rsp_data.probes == 4'd0)
      else $error("A full-table item reports a slot or probes.");

   a_miss_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == oaht_pkg::ST_NO_PATH ||
                    rsp_data.status == oaht_pkg::ST_NOT_FOUND)
         |-> rsp_data.slot == 3'd0)
      else $error("A failed item reports a nonzero slot.");

   a_clear_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready)
      else $error("An item was offered acceptance before the table was cleared.");

endmodule

bind open_addressing_hash_table oaht_checker u_oaht_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the open-addressing hash table.
// Needs oaht_pkg and open_addressing_hash_table; it predicts each result in place.
module testbench;

   localparam int SLOTS        = 8;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int IDLE_SETTLE  = 4;
   localparam int END_SETTLE   = 60;
   localparam int RAND_PHASES  = 8;
   localparam int PHASE_ITEMS  = 68;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              csr_wr_en   = 1'b0;
   logic              csr_wr_data = 1'b0;
   logic              req_valid   = 1'b0;
   logic              req_ready;
   oaht_pkg::req_type req_data    = '0;
   logic              rsp_valid;
   logic              rsp_ready   = 1'b0;
   oaht_pkg::rsp_type rsp_data;

   bit                quad_mode;
   bit                slot_used [SLOTS];
   logic [31:0]       slot_keys [SLOTS];
   oaht_pkg::rsp_type awaited_results [$];
   oaht_pkg::rsp_type oldest_result;
   int                mismatches;
   int                cycle_count;
   int                send_gap_max;
   int                rsp_stall_max;

   open_addressing_hash_table #(
      .TABLE_SIZE(SLOTS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic int path_slot(int home, int n);
      int i;
      int off;
      if (!quad_mode) begin
         return (home + n) % SLOTS;
      end
      if (n == 0) begin
         return home;
      end
      i   = (n + 1) / 2;
      off = (i * i) % SLOTS;
      if (n % 2 == 1) begin
         return (home + off) % SLOTS;
      end
      return (home + SLOTS - off) % SLOTS;
   endfunction

   // Applies one item to the predicted table and returns the result it causes.
   function automatic oaht_pkg::rsp_type probe_result(oaht_pkg::req_type item);
      oaht_pkg::rsp_type r;
      int      home;
      int      span;
      int      p;
      bit      any_free;
      home     = int'(item.key % SLOTS);
      span     = quad_mode ? 2 * SLOTS - 1 : SLOTS;
      r.status = oaht_pkg::ST_NOT_FOUND;
      r.slot   = '0;
      r.probes = 4'(span);
      if (item.func == oaht_pkg::FUNC_INSERT) begin
         any_free = 1'b0;
         for (int s = 0; s < SLOTS; s++) begin
            if (!slot_used[s]) begin
               any_free = 1'b1;
            end
         end
         if (!any_free) begin
            r.status = oaht_pkg::ST_FULL;
            r.probes = '0;
            return r;
         end
         r.status = oaht_pkg::ST_NO_PATH;
         for (int n = 0; n < span; n++) begin
            p = path_slot(home, n);
            if (!slot_used[p]) begin
               slot_used[p] = 1'b1;
               slot_keys[p] = item.key;
               r.status     = oaht_pkg::ST_INSERTED;
               r.slot       = 3'(p);
               r.probes     = 4'(n + 1);
               return r;
            end
         end
      end else begin
         for (int n = 0; n < span; n++) begin
            p = path_slot(home, n);
            if (slot_used[p] && slot_keys[p] == item.key) begin
               r.status = oaht_pkg::ST_FOUND;
               r.slot   = 3'(p);
               r.probes = 4'(n + 1);
               return r;
            end
         end
      end
      return r;
   endfunction

   task automatic send_item(input logic op, input logic [31:0] key_value);
      int                gap;
      oaht_pkg::req_type item;
      item.func = op;
      item.key  = key_value;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      awaited_results.push_back(probe_result(item));
   endtask

   task automatic wait_idle;
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   task automatic set_probe_mode(input bit mode);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      quad_mode = mode;
      csr_wr_en <= 1'b0;
   endtask

   task automatic test_linear_probing;
      wait_idle();
      set_probe_mode(1'b0);
      send_item(oaht_pkg::FUNC_LOOKUP, 32'h0000_0000);
      send_item(oaht_pkg::FUNC_INSERT, 32'h0000_0000);
      send_item(oaht_pkg::FUNC_INSERT, 32'hFFFF_FFFF);
      send_item(oaht_pkg::FUNC_INSERT, 32'h0000_0008);
      send_item(oaht_pkg::FUNC_INSERT, 32'h0000_0000);
      send_item(oaht_pkg::FUNC_INSERT, 32'hFFFF_FFF7);
      send_item(oaht_pkg::FUNC_LOOKUP, 32'h0000_0000);
      send_item(oaht_pkg::FUNC_LOOKUP, 32'hFFFF_FFF7);
      send_item(oaht_pkg::FUNC_LOOKUP, 32'h8000_0000);
   endtask

   task automatic test_quadratic_probing;
      wait_idle();
      set_probe_mode(1'b1);
      send_item(oaht_pkg::FUNC_INSERT, 32'h0000_0010);
      send_item(oaht_pkg::FUNC_INSERT, 32'h0000_0018);
      send_item(oaht_pkg::FUNC_LOOKUP, 32'hFFFF_FFF7);
      send_item(oaht_pkg::FUNC_LOOKUP, 32'h0000_0008);
      send_item(oaht_pkg::FUNC_LOOKUP, 32'h0000_0000);
      send_item(oaht_pkg::FUNC_LOOKUP, 32'h0000_000A);
   endtask

   task automatic test_full_table;
      wait_idle();
      send_item(oaht_pkg::FUNC_INSERT, 32'hDEAD_BEEE);
      send_item(oaht_pkg::FUNC_INSERT, 32'h0000_0005);
      send_item(oaht_pkg::FUNC_INSERT, 32'h0000_0003);
      send_item(oaht_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF);
      wait_idle();
      set_probe_mode(1'b0);
      send_item(oaht_pkg::FUNC_LOOKUP, 32'h0000_0010);
      send_item(oaht_pkg::FUNC_INSERT, 32'hAAAA_AAAA);
      send_item(oaht_pkg::FUNC_LOOKUP, 32'h0000_0018);
   endtask

   task automatic test_random_traffic;
      int          pick;
      int          s;
      logic [31:0] key_value;
      for (int phase = 0; phase < RAND_PHASES; phase++) begin
         wait_idle();
         set_probe_mode(phase < 2 ? phase[0] : 1'($urandom_range(0, 1)));
         send_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 16;
         rsp_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 16;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            pick      = $urandom_range(0, 99);
            s         = $urandom_range(0, SLOTS - 1);
            key_value = $urandom();
            if (pick < 55 && slot_used[s]) begin
               send_item(oaht_pkg::FUNC_LOOKUP, slot_keys[s]);
            end else if (pick < 70 && slot_used[s]) begin
               send_item(oaht_pkg::FUNC_LOOKUP,
                         slot_keys[s] ^ (32'h1 << $urandom_range(0, 31)));
            end else if (pick < 85) begin
               send_item(oaht_pkg::FUNC_LOOKUP, key_value);
            end else begin
               send_item(oaht_pkg::FUNC_INSERT, key_value);
            end
         end
      end
   endtask

   initial begin
      send_gap_max  = 16;
      rsp_stall_max = 16;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      test_linear_probing();
      test_quadratic_probing();
      test_full_table();
      test_random_traffic();
      wait_idle();
      repeat (END_SETTLE) @(posedge clock);
      if (mismatches == 0 && awaited_results.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      int stall;
      forever begin
         stall = $urandom_range(0, rsp_stall_max);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected result: status %0d slot %0d probes %0d",
                        rsp_data.status, rsp_data.slot, rsp_data.probes);
            end
         end else begin
            oldest_result = awaited_results.pop_front();
            if (rsp_data.status !== oldest_result.status ||
                rsp_data.slot !== oldest_result.slot ||
                rsp_data.probes !== oldest_result.probes) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("result mismatch: expected status %0d slot %0d probes %0d,",
                           oldest_result.status, oldest_result.slot,
                           oldest_result.probes);
                  $display("   got status %0d slot %0d probes %0d",
                           rsp_data.status, rsp_data.slot, rsp_data.probes);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

endmodule

// ----- open_addressing_hash_table.f -----
hw/rtl/oaht_pkg.sv
hw/rtl/oaht_ctrl.sv
hw/rtl/oaht_dpath.sv
hw/rtl/open_addressing_hash_table.sv
hw/rtl/oaht_checker.sv
bench/testbench.sv
